[rtl/cel_pkg.sv]
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types, constants and the natural-log table for the
// cross-entropy loss block.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int FRAC_BITS           = 16;
    localparam int LOG_TABLE_ADDR_BITS = 8;
    localparam int TBL_SEGS            = 1 << LOG_TABLE_ADDR_BITS;
    localparam int LOW_BITS            = 31 - LOG_TABLE_ADDR_BITS;
    localparam int ROM_W               = 31;
    localparam int VAL_W               = FRAC_BITS + 1;
    localparam int K_W                 = $clog2(FRAC_BITS);
    localparam int E_W                 = $clog2(FRAC_BITS + 1);
    localparam int NEGLOG_W            = FRAC_BITS + 4;
    localparam int PROD_W              = VAL_W + NEGLOG_W;
    localparam int V_W                 = ROM_W + E_W;
    localparam int QDEPTH              = 8;
    localparam int QPTR_W              = $clog2(QDEPTH);
    localparam int QCNT_W              = $clog2(QDEPTH + 1);
    localparam int LOSS_W              = 32;
    localparam int ROWS_W              = 16;

    typedef struct packed {
        logic [VAL_W-1:0] target_value;
        logic [VAL_W-1:0] predicted_prob;
        logic             end_of_row;
        logic             end_of_matrix;
    } cel_item_t;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [ROWS_W-1:0] rows_seen;
    } cel_result_t;

    // product word passed from the log pipeline to the accumulator
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              eor;
        logic              eom;
    } cel_prod_t;

    typedef logic [ROM_W-1:0] ln_rom_t [0:TBL_SEGS];

    // restoring long division, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/TBL_SEGS) in Q30 by the atanh series
    function automatic logic [ROM_W-1:0] ln_entry(input int i);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] res;
        z   = div_u64(64'(i) << 32, 64'(2 * TBL_SEGS + i));
        z2  = (z * z) >> 32;
        pw  = z;
        sum = '0;
        k   = 64'd1;
        for (int n = 0; n < 256; n++)
        begin
            if (pw != 64'd0)
            begin
                sum = sum + div_u64(pw, k);
                pw  = (pw * z2) >> 32;
                k   = k + 64'd2;
            end
        end
        res = (64'd2 * sum + 64'd2) >> 2;
        return res[ROM_W-1:0];
    endfunction

    function automatic ln_rom_t build_rom();
        ln_rom_t rom;
        for (int i = 0; i <= TBL_SEGS; i++)
        begin
            rom[i] = ln_entry(i);
        end
        return rom;
    endfunction

    localparam ln_rom_t LN_ROM = build_rom();

endpackage

[rtl/cross_entropy_loss_top.sv]
// ----------------------------------------------------------------------------
// cross_entropy_loss_top
// Streaming categorical cross-entropy loss over a target and prediction
// matrix in row order.
// ----------------------------------------------------------------------------
// Usage:
//   item_valid/item_ready/item carry one element pair per word, with end of
//   row and end of matrix marks. result_valid/result_ready/result carry one
//   word per matrix: mean loss per row (Q16.16, saturated) and row count.
//   Throughput: one element per cycle while the mean divider is idle, through the
//   five stage log pipeline (clamp, normalise and table read, interpolation
//   multiply, log assembly, target multiply) and the accumulator.
//   An element passes the five pipeline registers and the queue before it
//   reaches the accumulator; a matrix result appears once the bit-serial mean
//   divider has finished that matrix and the result register is free. While the
//   divider works, elements gather in the 8 word queue and item_ready drops once
//   8 words are in flight.
//   Reset clears the accumulator, row count, queue and pending result.
//   A stalled receiver holds the result word; the divider waits for it to
//   leave, then the queue backs up to the input.
// ----------------------------------------------------------------------------
module cross_entropy_loss_top
    import cel_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  cel_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output cel_result_t result
);

    logic              front_valid;
    cel_prod_t         front_prod;
    logic              q_not_empty;
    cel_prod_t         q_head;
    logic              q_pop;
    logic              accept;
    logic [QCNT_W-1:0] inflight_reg;

    assign accept     = item_valid && item_ready;
    assign item_ready = (inflight_reg < QCNT_W'(QDEPTH));

    // words between acceptance and queue read, bounds queue fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + QCNT_W'(accept) - QCNT_W'(q_pop);
    end

    cel_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (front_valid),
        .out_prod  (front_prod)
    );

    cel_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_word (front_prod),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (q_head)
    );

    cel_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (q_not_empty),
        .word         (q_head),
        .word_pop     (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // in-flight count never exceeds queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= QCNT_W'(QDEPTH))
        else $error("in-flight count beyond queue depth");

endmodule

[rtl/cel_front.sv]
// ----------------------------------------------------------------------------
// cel_front
// Clamp, table log with interpolation and target multiply, five stages,
// advancing every cycle.
// ----------------------------------------------------------------------------
module cel_front
    import cel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  cel_item_t in_item,
    output logic      out_valid,
    output cel_prod_t out_prod
);

    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                   s5_valid_reg;
    logic [VAL_W-1:0]       s1_t_reg, s2_t_reg, s3_t_reg, s4_t_reg;
    logic [FRAC_BITS-1:0]   s1_p_reg;
    logic [1:0]             s1_f_reg, s2_f_reg, s3_f_reg, s4_f_reg;
    logic [ROM_W-1:0]       s2_lo_reg, s2_hi_reg, s3_lo_reg;
    logic [LOW_BITS-1:0]    s2_low_reg;
    logic [E_W-1:0]         s2_e_reg, s3_e_reg;
    logic [ROM_W+LOW_BITS-1:0] s3_mul_reg;
    logic [NEGLOG_W-1:0]    s4_nl_reg;
    cel_prod_t              s5_reg;

    logic [FRAC_BITS-1:0]   p_clamp;
    logic [K_W-1:0]         msb_k;
    logic [31:0]            norm;
    logic [LOG_TABLE_ADDR_BITS-1:0] idx;
    logic [LOG_TABLE_ADDR_BITS:0]   idx_hi;
    logic [V_W-1:0]         lnm;
    logic [V_W-1:0]         v;
    logic [V_W-1:0]         v_rnd;

    // probability clamp to one lsb .. one minus one lsb
    always_comb
    begin
        if (in_item.predicted_prob[VAL_W-1])
            p_clamp = '1;
        else if (in_item.predicted_prob[FRAC_BITS-1:0] == '0)
            p_clamp = FRAC_BITS'(1);
        else
            p_clamp = in_item.predicted_prob[FRAC_BITS-1:0];
    end

    // leading one search and normalisation
    always_comb
    begin
        msb_k = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            if (s1_p_reg[i])
                msb_k = K_W'(i);
        end
        norm   = 32'(s1_p_reg) << (5'd31 - 5'(msb_k));
        idx    = norm[30 -: LOG_TABLE_ADDR_BITS];
        idx_hi = {1'b0, idx} + 1'b1;
    end

    // log assembly and rounding to the output fraction
    always_comb
    begin
        lnm   = V_W'(s3_lo_reg) + V_W'(s3_mul_reg >> LOW_BITS);
        v     = V_W'(s3_e_reg) * V_W'(LN_ROM[TBL_SEGS]) - lnm;
        v_rnd = (v + (V_W'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        s1_t_reg   <= in_item.target_value;
        s1_p_reg   <= p_clamp;
        s1_f_reg   <= {in_item.end_of_row, in_item.end_of_matrix};

        s2_t_reg   <= s1_t_reg;
        s2_f_reg   <= s1_f_reg;
        s2_lo_reg  <= LN_ROM[idx];
        s2_hi_reg  <= LN_ROM[idx_hi];
        s2_low_reg <= norm[LOW_BITS-1:0];
        s2_e_reg   <= E_W'(FRAC_BITS) - E_W'(msb_k);

        s3_t_reg   <= s2_t_reg;
        s3_f_reg   <= s2_f_reg;
        s3_lo_reg  <= s2_lo_reg;
        s3_e_reg   <= s2_e_reg;
        s3_mul_reg <= (ROM_W+LOW_BITS)'(s2_hi_reg - s2_lo_reg)
                      * (ROM_W+LOW_BITS)'(s2_low_reg);

        s4_t_reg   <= s3_t_reg;
        s4_f_reg   <= s3_f_reg;
        s4_nl_reg  <= v_rnd[NEGLOG_W-1:0];

        s5_reg.prod <= PROD_W'(s4_t_reg) * PROD_W'(s4_nl_reg);
        s5_reg.eor  <= s4_f_reg[1];
        s5_reg.eom  <= s4_f_reg[0];
    end

    assign out_valid = s5_valid_reg;
    assign out_prod  = s5_reg;

endmodule

[rtl/cel_queue.sv]
// ----------------------------------------------------------------------------
// cel_queue
// Short first-in first-out queue of product words between the log
// pipeline and the accumulator.
// ----------------------------------------------------------------------------
module cel_queue
    import cel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cel_prod_t push_word,
    input  logic      pop,
    output logic      not_empty,
    output cel_prod_t head_word
);

    cel_prod_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QDEPTH)) |-> (!push || pop))
        else $error("queue overflow");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

endmodule

[rtl/cel_back.sv]
// ----------------------------------------------------------------------------
// cel_back
// Saturating accumulator, row counter, bit-serial mean divider and
// result register.
// ----------------------------------------------------------------------------
module cel_back
    import cel_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    input  cel_prod_t   word,
    output logic        word_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output cel_result_t result
);

    localparam int DVD_W = ACC_WIDTH - FRAC_BITS + 1;
    localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam int Q_W   = ((DVD_W > LOSS_W) ? DVD_W : LOSS_W) + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic [ROWS_W-1:0]    rows_reg, rows_next;
    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [ROWS_W-1:0]    rem_reg;
    logic [ROWS_W-1:0]    div_rows_reg;
    logic                 result_valid_reg;
    cel_result_t          result_reg;

    logic [SUM_W-1:0]     sum;
    logic [ROWS_W:0]      rem_sh;
    logic                 q_bit;
    logic [Q_W-1:0]       q_rnd;
    logic                 finish;

    assign word_pop = word_valid && !busy_reg;

    // saturating accumulate and row count
    always_comb
    begin
        sum = SUM_W'(acc_reg) + SUM_W'(word.prod);
        if (sum > SUM_W'({ACC_WIDTH{1'b1}}))
            acc_next = '1;
        else
            acc_next = sum[ACC_WIDTH-1:0];
        rows_next = rows_reg;
        if ((word.eor || word.eom) && (rows_reg != '1))
            rows_next = rows_reg + 1'b1;
    end

    // one quotient bit per cycle, then round half up and saturate
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        q_bit  = (rem_sh >= {1'b0, div_rows_reg});
        q_rnd  = (Q_W'(dvd_reg) + 1'b1) >> 1;
        finish = busy_reg && (cnt_reg == '0) && (!result_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            rows_reg         <= '0;
            busy_reg         <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (word_pop)
            begin
                if (word.eom)
                begin
                    acc_reg  <= '0;
                    rows_reg <= '0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DVD_W);
                end
                else
                begin
                    acc_reg  <= acc_next;
                    rows_reg <= rows_next;
                end
            end
            if (busy_reg && (cnt_reg != '0))
                cnt_reg <= cnt_reg - 1'b1;
            if (finish)
                busy_reg <= 1'b0;
            if (finish)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // divider datapath and result word
    always_ff @(posedge clk)
    begin
        if (word_pop && word.eom)
        begin
            dvd_reg      <= acc_next[ACC_WIDTH-1:FRAC_BITS-1];
            div_rows_reg <= rows_next;
            rem_reg      <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= q_bit ? ROWS_W'(rem_sh - {1'b0, div_rows_reg}) : rem_sh[ROWS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
        end
        if (finish)
        begin
            if (q_rnd > Q_W'({LOSS_W{1'b1}}))
                result_reg.loss <= '1;
            else
                result_reg.loss <= q_rnd[LOSS_W-1:0];
            result_reg.rows_seen <= div_rows_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the divisor is never zero while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (cnt_reg != '0)) |-> (div_rows_reg != '0))
        else $error("zero row count in divider");

    // a result is only loaded when the previous one has left
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(result_reg))
        else $error("pending result overwritten");

endmodule

[sim/cel_checker.sv]
// ----------------------------------------------------------------------------
// cel_checker
// Watches both channels of the cross-entropy loss block, predicts each
// matrix result from the accepted element words and compares it with the
// result word that comes out.
// ----------------------------------------------------------------------------
module cel_checker
    import cel_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  cel_item_t   item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  cel_result_t result,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SUM_MAX = (~64'd0) >> (64 - ACC_WIDTH);

    logic [63:0] ln_table [0:TBL_SEGS];
    logic [63:0] loss_sum;
    int unsigned row_count;
    cel_result_t expected_losses [$];

    // ln(1 + i/TBL_SEGS) in Q30, atanh series
    function automatic logic [63:0] ln_seg(input int unsigned i);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] k;
        z   = (64'(i) << 32) / 64'(2 * TBL_SEGS + i);
        z2  = (z * z) >> 32;
        pw  = z;
        acc = 0;
        k   = 1;
        while (pw != 0)
        begin
            acc = acc + pw / k;
            pw  = (pw * z2) >> 32;
            k   = k + 2;
        end
        return (2 * acc + 2) >> 2;
    endfunction

    // -ln(p) in Q.FRAC_BITS, p already clamped
    function automatic logic [63:0] neg_log(input logic [63:0] p);
        int          k;
        logic [63:0] norm;
        logic [63:0] frac;
        logic [63:0] idx;
        logic [63:0] low;
        logic [63:0] lnm;
        logic [63:0] v;
        k = 0;
        while (k < 63 && (p >> (k + 1)) != 0)
            k++;
        norm = (p << (31 - k)) & 64'hFFFF_FFFF;
        frac = norm & 64'h7FFF_FFFF;
        idx  = (frac >> LOW_BITS) & (TBL_SEGS - 1);
        low  = frac & ((64'd1 << LOW_BITS) - 1);
        lnm  = ln_table[idx] + (((ln_table[idx + 1] - ln_table[idx]) * low) >> LOW_BITS);
        v    = 64'(FRAC_BITS - k) * ln_table[TBL_SEGS] - lnm;
        return (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    endfunction

    initial
    begin
        for (int i = 0; i <= TBL_SEGS; i++)
            ln_table[i] = ln_seg(i);
    end

    assign pending_count = expected_losses.size();

    // predict on input words, compare on result words
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] p;
        logic [63:0] prod;
        logic [63:0] denom;
        logic [63:0] q;
        logic [63:0] r;
        cel_result_t want;
        if (!rst_n)
        begin
            loss_sum   <= 0;
            row_count  <= 0;
            fail_count <= 0;
            expected_losses.delete();
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                p = 64'(item.predicted_prob);
                if (p < 1)
                    p = 1;
                if (p > (64'd1 << FRAC_BITS) - 1)
                    p = (64'd1 << FRAC_BITS) - 1;
                prod = 64'(item.target_value) * neg_log(p);
                q = (prod > SUM_MAX - loss_sum) ? SUM_MAX : loss_sum + prod;
                r = ((item.end_of_row || item.end_of_matrix) && row_count < 65535)
                    ? row_count + 1 : row_count;
                if (item.end_of_matrix)
                begin
                    denom = r << FRAC_BITS;
                    want.rows_seen = r[15:0];
                    r = q % denom;
                    q = q / denom;
                    if (2 * r >= denom)
                        q++;
                    if (q > 64'hFFFF_FFFF)
                        q = 64'hFFFF_FFFF;
                    want.loss = q[31:0];
                    expected_losses.push_back(want);
                    loss_sum  <= 0;
                    row_count <= 0;
                end
                else
                begin
                    loss_sum  <= q;
                    row_count <= 32'(r);
                end
            end
            if (result_valid && result_ready)
            begin
                if (expected_losses.size() == 0)
                begin
                    $display("%t: unexpected result word loss=%h rows=%0d",
                             $time, result.loss, result.rows_seen);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_losses.pop_front();
                    if (want.loss !== result.loss || want.rows_seen !== result.rows_seen)
                    begin
                        $display("%t: mismatch expected loss=%h rows=%0d, actual loss=%h rows=%0d",
                                 $time, want.loss, want.rows_seen, result.loss,
                                 result.rows_seen);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives element words of random and corner-case matrices into the
// cross-entropy loss block with random gaps and receiver stalls; the
// checker predicts and compares every matrix result.
// ----------------------------------------------------------------------------
module testbench;
    import cel_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    cel_item_t   item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    cel_result_t result;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          hold_used = 1'b0;

    cross_entropy_loss_top dut (.*);

    cel_checker checker_i (.*);

    always #5 clk = ~clk;

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // send one element word and wait for acceptance
    task automatic send_word(input logic [16:0] t, input logic [16:0] p,
                             input logic eor, input logic eom);
        item_valid <= 1'b1;
        item <= '{target_value: t, predicted_prob: p, end_of_row: eor, end_of_matrix: eom};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [16:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(1, 255));
            default: return 17'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // random matrix of small shape
    task automatic send_matrix(input int rows, input int cols, input bit gaps);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
            begin
                logic last_col;
                logic last;
                last_col = (c == cols - 1);
                last = last_col && (r == rows - 1);
                // occasionally drop the row mark on the matrix end
                send_word(rand_val(), rand_val(), last_col && !(last && $urandom_range(0, 3) == 0),
                          last);
                if (gaps)
                    idle_gap($urandom_range(0, 2) == 0 ? gap_len() : 0);
            end
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and special cases
        send_word(17'd65536, 17'd0, 1'b1, 1'b0);
        send_word(17'd65536, 17'd65536, 1'b1, 1'b0);
        send_word(17'h1FFFF, 17'h1FFFF, 1'b0, 1'b0);
        send_word(17'h1FFFF, 17'd1, 1'b1, 1'b1);
        send_word(17'd0, 17'd32768, 1'b0, 1'b1);
        send_word(17'd65536, 17'd65535, 1'b1, 1'b1);
        send_word(17'd32768, 17'd1, 1'b0, 1'b0);
        send_word(17'd32768, 17'd3, 1'b1, 1'b1);
        // large sums to push output and accumulator towards saturation
        for (int i = 0; i < 10; i++)
            send_word(17'h1FFFF, 17'd0, 1'b0, i == 9);
        wait_drained();

        // long receiver hold-off while the sender keeps going
        hold_off <= 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
            for (int m = 0; m < 12; m++)
                send_matrix(1, 2, 1'b0);
        join
        wait_drained();

        // random part
        n = 0;
        while (n < 430)
        begin
            int rows;
            int cols;
            rows = $urandom_range(1, 4);
            cols = $urandom_range(1, 5);
            send_matrix(rows, cols, 1'b1);
            n += rows * cols;
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/cel_pkg.sv
rtl/cel_front.sv
rtl/cel_queue.sv
rtl/cel_back.sv
rtl/cross_entropy_loss_top.sv
sim/cel_checker.sv
sim/testbench.sv
